// File: design/gse_pkg.sv
// ----------------------------------------------------------------------------
// gse_pkg
// Shared types and constants of the GF(2) syndrome engine: beat layout,
// command and register codes, and the accumulator control bundle.
// ----------------------------------------------------------------------------
package gse_pkg;

  // default matrix geometry
  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 64;

  // fixed field widths
  localparam int VEC_W      = 64;
  localparam int IDX_W      = 6;
  localparam int TGT_W      = 32;
  localparam int ROW_IDX_W  = 5;
  localparam int CMD_W      = 3;
  localparam int ROWS_REG_W = 6;
  localparam int COLS_REG_W = 7;
  localparam int CMPC_REG_W = 6;

  // beat widths
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [CFG_IDX_W-1:0] reg_idx_t;

  // command codes
  localparam cmd_t CMD_LOAD  = 3'd0;
  localparam cmd_t CMD_SYN   = 3'd1;
  localparam cmd_t CMD_TRN   = 3'd2;
  localparam cmd_t CMD_CHK   = 3'd3;
  localparam cmd_t CMD_CHKZ  = 3'd4;

  // register indexes
  localparam reg_idx_t REG_ROWS = 2'd0;
  localparam reg_idx_t REG_COLS = 2'd1;
  localparam reg_idx_t REG_CMPC = 2'd2;

  // accumulator control bundle
  typedef struct packed {
    logic             clear;
    logic             step;
    logic             transpose;
    logic [IDX_W-1:0] pos;
  } acc_ctrl_t;

endpackage

// File: design/gf2_syndrome_engine_unit.sv
// ----------------------------------------------------------------------------
// gf2_syndrome_engine_unit
// GF(2) parity-check matrix store with syndrome, transpose product and
// syndrome check commands, one stored row handled per cycle.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+----------------------------------
//  in_      | in  | in_tvalid/in_tready | tuser: command; tdata: row fields
//  out_     | out | out_tvalid/tready   | tdata: result_vector, verdict
//  cfg_     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  load row and unknown commands give no result beat
//  product and check commands hold in_tready low from accept until the result
//  beat is registered, through the run and finish states over the n rows in use;
//  the row loop reads one matrix row per cycle through one read port
//  rst_n is synchronous; the matrix memory is not cleared
//  a waiting result beat does not block loads; a new result waits for it
// ----------------------------------------------------------------------------
module gf2_syndrome_engine_unit
  import gse_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // slave stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [4:0] row_index, [68:5] row_bits, [132:69] vector,
  // [164:133] target_syndrome, [167:165] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [2:0] command
  input  logic [CMD_W-1:0]       in_tuser,
  // master stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [63:0] result_vector, [64] verdict, [71:65] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_t;

  // beat fields
  cmd_t                 in_cmd;
  logic [ROW_IDX_W-1:0] in_row_idx;
  logic [VEC_W-1:0]     in_row_bits;
  logic [VEC_W-1:0]     in_vec;
  logic [TGT_W-1:0]     in_target;

  assign in_cmd      = in_tuser;
  assign in_row_idx  = in_tdata[4:0];
  assign in_row_bits = in_tdata[68:5];
  assign in_vec      = in_tdata[132:69];
  assign in_target   = in_tdata[164:133];

  // configuration registers
  logic [ROWS_REG_W-1:0] rows_in_use_r;
  logic [COLS_REG_W-1:0] cols_in_use_r;
  logic [CMPC_REG_W-1:0] compare_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r   <= ROWS_REG_W'(32);
      cols_in_use_r   <= COLS_REG_W'(64);
      compare_count_r <= CMPC_REG_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS: rows_in_use_r   <= cfg_data[ROWS_REG_W-1:0];
        REG_COLS: cols_in_use_r   <= cfg_data[COLS_REG_W-1:0];
        REG_CMPC: compare_count_r <= cfg_data[CMPC_REG_W-1:0];
        default:  ;
      endcase
    end
  end

  // sizes in effect, saturated to the storage
  logic [CW-1:0]    eff_rows;
  logic [VEC_W-1:0] col_mask;
  logic [TGT_W-1:0] cmp_mask;

  always_comb begin
    int ncols;
    int ncmp;
    if (int'(rows_in_use_r) > MAX_ROWS) begin
      eff_rows = CW'(MAX_ROWS);
    end else begin
      eff_rows = CW'(rows_in_use_r);
    end
    ncols = int'(cols_in_use_r);
    if (ncols > MAX_COLS) begin
      ncols = MAX_COLS;
    end
    if (ncols >= VEC_W) begin
      col_mask = '1;
    end else begin
      col_mask = (VEC_W'(1) << ncols) - VEC_W'(1);
    end
    ncmp = int'(compare_count_r);
    if (ncmp > int'(eff_rows)) begin
      ncmp = int'(eff_rows);
    end
    if (ncmp >= TGT_W) begin
      cmp_mask = '1;
    end else begin
      cmp_mask = (TGT_W'(1) << ncmp) - TGT_W'(1);
    end
  end

  // sequencer registers
  state_t               state_r,     state_nxt;
  logic [CW-1:0]        issue_idx_r, issue_idx_nxt;
  logic                 pend_r,      pend_nxt;
  logic [AW-1:0]        pend_idx_r,  pend_idx_nxt;
  cmd_t                 cmd_r,       cmd_nxt;
  logic [CW-1:0]        rows_r,      rows_nxt;
  logic [VEC_W-1:0]     col_mask_r,  col_mask_nxt;
  logic [TGT_W-1:0]     cmp_mask_r,  cmp_mask_nxt;
  logic [VEC_W-1:0]     vec_r,       vec_nxt;
  logic [TGT_W-1:0]     target_r,    target_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VEC_W-1:0]     out_vec_r,   out_vec_nxt;
  logic                 out_verd_r,  out_verd_nxt;

  logic                 in_fire;
  logic                 is_product;
  logic                 issue_go;
  logic                 out_free;
  logic                 verdict;
  logic [VEC_W-1:0]     acc;
  logic [TGT_W-1:0]     syn_lo;
  acc_ctrl_t            acc_ctrl;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign is_product = (in_cmd == CMD_SYN) || (in_cmd == CMD_TRN) ||
                      (in_cmd == CMD_CHK) || (in_cmd == CMD_CHKZ);
  assign issue_go   = (state_r == S_RUN) && (issue_idx_r != rows_r);
  assign out_free   = !out_valid_r || out_tready;

  // verdict of the check commands over the compared bits
  assign syn_lo = acc[TGT_W-1:0];
  always_comb begin
    logic match;
    logic zero;
    match   = ((syn_lo ^ target_r) & cmp_mask_r) == '0;
    zero    = (syn_lo & cmp_mask_r) == '0;
    verdict = ((cmd_r == CMD_CHK) && match) ||
              ((cmd_r == CMD_CHKZ) && (match || zero));
  end

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    issue_idx_nxt = issue_idx_r;
    pend_nxt      = issue_go;
    pend_idx_nxt  = issue_idx_r[AW-1:0];
    cmd_nxt       = cmd_r;
    rows_nxt      = rows_r;
    col_mask_nxt  = col_mask_r;
    cmp_mask_nxt  = cmp_mask_r;
    vec_nxt       = vec_r;
    target_nxt    = target_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_vec_nxt   = out_vec_r;
    out_verd_nxt  = out_verd_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && is_product) begin
          state_nxt     = S_RUN;
          issue_idx_nxt = '0;
          cmd_nxt       = in_cmd;
          rows_nxt      = eff_rows;
          col_mask_nxt  = col_mask;
          cmp_mask_nxt  = cmp_mask;
          vec_nxt       = in_vec;
          target_nxt    = in_target;
        end
      end
      S_RUN: begin
        if (issue_go) begin
          issue_idx_nxt = issue_idx_r + CW'(1);
        end else if (!pend_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_vec_nxt   = acc;
          out_verd_nxt  = verdict;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_idx_r <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_idx_r <= issue_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_idx_r <= pend_idx_nxt;
    cmd_r      <= cmd_nxt;
    rows_r     <= rows_nxt;
    col_mask_r <= col_mask_nxt;
    cmp_mask_r <= cmp_mask_nxt;
    vec_r      <= vec_nxt;
    target_r   <= target_nxt;
    out_vec_r  <= out_vec_nxt;
    out_verd_r <= out_verd_nxt;
  end

  // matrix memory, one write and one registered read port
  logic [MAX_COLS-1:0] mem_r [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (in_fire && (in_cmd == CMD_LOAD) && (int'(in_row_idx) < MAX_ROWS)) begin
      mem_r[AW'(in_row_idx)] <= in_row_bits[MAX_COLS-1:0];
    end
    if (issue_go) begin
      rd_data_r <= mem_r[issue_idx_r[AW-1:0]];
    end
  end

  // shared row unit
  assign acc_ctrl.clear     = in_fire && is_product;
  assign acc_ctrl.step      = pend_r;
  assign acc_ctrl.transpose = (cmd_r == CMD_TRN);
  assign acc_ctrl.pos       = IDX_W'(pend_idx_r);

  gse_accum u_accum (
    .clk      (clk),
    .ctrl     (acc_ctrl),
    .row_data (VEC_W'(rd_data_r)),
    .vec      (vec_r),
    .col_mask (col_mask_r),
    .acc      (acc)
  );

  // result beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_verd_r, out_vec_r};

`ifndef SYNTHESIS
  // the row loop never reads past the rows in use
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (issue_idx_r <= rows_r))
    else $error("row issue index beyond rows in use");

  // no row still in flight when the loop ends
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> !pend_r)
    else $error("row step pending after loop end");

  // products give a zero verdict
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && out_free && ((cmd_r == CMD_SYN) || (cmd_r == CMD_TRN)))
    |=> !out_verd_r)
    else $error("verdict set for a plain product");

  // a result beat is never overwritten while waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_vec_r)))
    else $error("waiting result beat overwritten");
`endif

endmodule

// File: design/gse_accum.sv
// ----------------------------------------------------------------------------
// gse_accum
// Shared row unit: masks one matrix row per step and either folds its parity
// against the vector into one syndrome bit, or xors it into acc if vec[pos].
// ----------------------------------------------------------------------------
module gse_accum
  import gse_pkg::*;
(
  input  logic             clk,
  input  acc_ctrl_t        ctrl,
  input  logic [VEC_W-1:0] row_data,
  input  logic [VEC_W-1:0] vec,
  input  logic [VEC_W-1:0] col_mask,
  output logic [VEC_W-1:0] acc
);

  logic [VEC_W-1:0] acc_r;
  logic [VEC_W-1:0] acc_nxt;
  logic [VEC_W-1:0] masked_row;
  logic             row_par;

  // row limited to the columns in use
  assign masked_row = row_data & col_mask;
  assign row_par    = ^(masked_row & vec);

  // one step: syndrome bit or transpose xor
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.step) begin
      if (ctrl.transpose) begin
        if (vec[ctrl.pos]) begin
          acc_nxt = acc_r ^ masked_row;
        end
      end else begin
        acc_nxt = acc_r | (VEC_W'(row_par) << ctrl.pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule
